FILE: design/bavg_pkg.sv
// Package for the 2x2 box-average downscaler.
// Holds the pixel, result and queue entry types plus shared constants.
// No dependencies.
`timescale 1ns / 1ps

package bavg_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Configuration register layout.
    localparam int CFG_W       = 11;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam int WIDTH_RESET  = 512;
    localparam int HEIGHT_RESET = 512;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Queue entry operations.
    localparam logic OP_STORE = 1'b0;
    localparam logic OP_EMIT  = 1'b1;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       row_end;
        logic       frame_end;
    } res_t;

    // One horizontal pair sum, 9 bits per channel.
    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } pair_t;

    typedef struct packed {
        logic  op;
        pair_t pair;
        logic  row_end;
        logic  frame_end;
    } cmd_t;

endpackage

FILE: design/bavg_front.sv
// Front end of the downscaler: accepts pixels, tracks position and forms pair sums.
// Pushes store or emit entries into the queue. Depends on bavg_pkg.
`timescale 1ns / 1ps

module bavg_front #(
    parameter int MAX_WIDTH  = bavg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bavg_pkg::MAX_HEIGHT_DEF,
    parameter int WW         = $clog2(MAX_WIDTH + 1),
    parameter int HW         = $clog2(MAX_HEIGHT + 1),
    parameter int SW         = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bavg_pkg::pix_t       in_data,
    input  logic [WW-1:0]        img_w,
    input  logic [HW-1:0]        img_h,
    input  logic                 q_full,
    output logic                 q_push,
    output bavg_pkg::cmd_t       q_cmd,
    output logic [SW-1:0]        q_slot
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    bavg_pkg::pix_t  held_reg;

    logic [WW-1:0] col_ext, col_inc, col_half, last_col;
    logic [HW-1:0] row_ext, row_inc, last_row;
    logic          accept, in_range;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign col_ext  = WW'(col_reg);
    assign row_ext  = HW'(row_reg);
    assign col_inc  = col_ext + WW'(1);
    assign row_inc  = row_ext + HW'(1);
    assign col_half = col_ext >> 1;
    assign in_range = (col_ext < img_w) && (row_ext < img_h);

    // An odd last column or row is never part of a block.
    assign last_col = {img_w[WW-1:1], 1'b0} - WW'(1);
    assign last_row = {img_h[HW-1:1], 1'b0} - HW'(1);

    assign q_push = accept && in_range && col_reg[0];
    assign q_slot = col_half[SW-1:0];

    always_comb
    begin
        q_cmd.op         = row_reg[0] ? bavg_pkg::OP_EMIT : bavg_pkg::OP_STORE;
        q_cmd.pair.red   = {1'b0, held_reg.red_in}   + {1'b0, in_data.red_in};
        q_cmd.pair.green = {1'b0, held_reg.green_in} + {1'b0, in_data.green_in};
        q_cmd.pair.blue  = {1'b0, held_reg.blue_in}  + {1'b0, in_data.blue_in};
        q_cmd.row_end    = (col_ext == last_col);
        q_cmd.frame_end  = (col_ext == last_col) && (row_ext == last_row);
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= img_w)
            begin
                col_next = '0;
                if (row_inc >= img_h)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_inc[RW-1:0];
                end
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept && in_range && !col_reg[0])
            begin
                held_reg <= in_data;
            end
        end
    end

endmodule

FILE: design/bavg_queue.sv
// Short queue of line-store operations between front and back.
// Entry type from bavg_pkg; the slot index width is a parameter.
`timescale 1ns / 1ps

module bavg_queue #(
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bavg_pkg::cmd_t  push_cmd,
    input  logic [SW-1:0]   push_slot,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output bavg_pkg::cmd_t  head_cmd,
    output logic [SW-1:0]   head_slot
);

    localparam int DEPTH = bavg_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    bavg_pkg::cmd_t cmd_reg [DEPTH];
    logic [SW-1:0]  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]  count_reg;

    assign full       = (count_reg == NW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = cmd_reg[rd_ptr_reg];
    assign head_slot  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wr_ptr_reg]  <= push_cmd;
            slot_reg[wr_ptr_reg] <= push_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

endmodule

FILE: design/bavg_back.sv
// Back end of the downscaler: owns the line store of pair sums.
// Stores even-row pairs, adds odd-row pairs and registers the result. Depends on bavg_pkg.
`timescale 1ns / 1ps

module bavg_back #(
    parameter int LINE_DEPTH = bavg_pkg::MAX_WIDTH_DEF / 2,
    parameter int SW         = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  bavg_pkg::cmd_t  q_cmd,
    input  logic [SW-1:0]   q_slot,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_stall,
    output bavg_pkg::res_t  out_data
);

    bavg_pkg::pair_t line_mem [LINE_DEPTH];

    // Read stage: line-store data plus the pair that goes with it.
    logic            rd_valid_reg;
    bavg_pkg::pair_t rd_data_reg;
    bavg_pkg::pair_t rd_pair_reg;
    logic            rd_row_end_reg, rd_frame_end_reg;

    logic            out_valid_reg;
    bavg_pkg::res_t  out_data_reg;

    logic out_free, rd_free, rd_move, pop_emit, pop_store;
    logic [9:0] sum_red, sum_green, sum_blue;

    assign out_free  = !out_valid_reg || !out_stall;
    assign rd_free   = !rd_valid_reg || out_free;
    assign rd_move   = rd_valid_reg && out_free;
    // A store needs only the memory port, so it never waits on the output.
    assign q_pop     = q_valid && ((q_cmd.op == bavg_pkg::OP_STORE) || rd_free);
    assign pop_store = q_pop && (q_cmd.op == bavg_pkg::OP_STORE);
    assign pop_emit  = q_pop && (q_cmd.op == bavg_pkg::OP_EMIT);

    assign sum_red   = {1'b0, rd_data_reg.red}   + {1'b0, rd_pair_reg.red};
    assign sum_green = {1'b0, rd_data_reg.green} + {1'b0, rd_pair_reg.green};
    assign sum_blue  = {1'b0, rd_data_reg.blue}  + {1'b0, rd_pair_reg.blue};

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (pop_store)
        begin
            line_mem[q_slot] <= q_cmd.pair;
        end
        if (pop_emit)
        begin
            rd_data_reg      <= line_mem[q_slot];
            rd_pair_reg      <= q_cmd.pair;
            rd_row_end_reg   <= q_cmd.row_end;
            rd_frame_end_reg <= q_cmd.frame_end;
        end
        if (rd_move)
        begin
            out_data_reg.red_out   <= sum_red[9:2];
            out_data_reg.green_out <= sum_green[9:2];
            out_data_reg.blue_out  <= sum_blue[9:2];
            out_data_reg.row_end   <= rd_row_end_reg;
            out_data_reg.frame_end <= rd_frame_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_free)
            begin
                rd_valid_reg <= pop_emit;
            end
            if (out_free)
            begin
                out_valid_reg <= rd_move;
            end
        end
    end

endmodule

FILE: design/box_average_downscale_2x.sv
// Top level of the 2x2 box-average downscaler: size registers and the three parts.
// Depends on bavg_pkg, bavg_front, bavg_queue and bavg_back.
//
//   Port group   Dir   Handshake           Payload
//   in_*         in    in_valid/in_stall   in_data (pix_t: red, green, blue)
//   out_*        out   out_valid/out_stall out_data (res_t: averages, row_end, frame_end)
//   cfg_*        in    cfg_we              cfg_index, cfg_data (11 bits)
//
// One pixel is taken per clock while in_stall is low; the line store has one port
// and is used once per item. A result passes the queue, read stage and output register.
// Reset clears the counters, the held pixel and all valid flags; the line store is
// not cleared and needs no sweep, since every entry is written before it is read.
// Input stalls only when four line-store operations are queued in front of the back end.
`timescale 1ns / 1ps

module box_average_downscale_2x #(
    parameter int MAX_WIDTH  = bavg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bavg_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bavg_pkg::pix_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bavg_pkg::res_t                      out_data,
    input  logic                                cfg_we,
    input  logic [bavg_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bavg_pkg::CFG_W-1:0]          cfg_data
);

    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);
    localparam int EW         = (WW > bavg_pkg::CFG_W) ? WW : bavg_pkg::CFG_W;
    localparam int EH         = (HW > bavg_pkg::CFG_W) ? HW : bavg_pkg::CFG_W;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int SW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int W_RESET    = (bavg_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                MAX_WIDTH : bavg_pkg::WIDTH_RESET;
    localparam int H_RESET    = (bavg_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                                MAX_HEIGHT : bavg_pkg::HEIGHT_RESET;

    // Sizes are kept already clamped to the supported range.
    logic [WW-1:0] img_w_reg, img_w_next;
    logic [HW-1:0] img_h_reg, img_h_next;
    logic [EW-1:0] cfg_w_ext;
    logic [EH-1:0] cfg_h_ext;

    logic            q_full, q_push, q_pop, q_valid;
    bavg_pkg::cmd_t  push_cmd, head_cmd;
    logic [SW-1:0]   push_slot, head_slot;

    assign cfg_w_ext = EW'(cfg_data);
    assign cfg_h_ext = EH'(cfg_data);

    always_comb
    begin
        if (cfg_w_ext < EW'(2))
        begin
            img_w_next = WW'(2);
        end
        else if (cfg_w_ext > EW'(MAX_WIDTH))
        begin
            img_w_next = WW'(MAX_WIDTH);
        end
        else
        begin
            img_w_next = cfg_w_ext[WW-1:0];
        end

        if (cfg_h_ext < EH'(2))
        begin
            img_h_next = HW'(2);
        end
        else if (cfg_h_ext > EH'(MAX_HEIGHT))
        begin
            img_h_next = HW'(MAX_HEIGHT);
        end
        else
        begin
            img_h_next = cfg_h_ext[HW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= WW'(W_RESET);
            img_h_reg <= HW'(H_RESET);
        end
        else if (cfg_we)
        begin
            if (cfg_index == bavg_pkg::REG_IMAGE_WIDTH)
            begin
                img_w_reg <= img_w_next;
            end
            if (cfg_index == bavg_pkg::REG_IMAGE_HEIGHT)
            begin
                img_h_reg <= img_h_next;
            end
        end
    end

    bavg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW),
        .SW         (SW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .img_w    (img_w_reg),
        .img_h    (img_h_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd),
        .q_slot   (push_slot)
    );

    bavg_queue #(
        .SW (SW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_slot  (push_slot),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd),
        .head_slot  (head_slot)
    );

    bavg_back #(
        .LINE_DEPTH (LINE_DEPTH),
        .SW         (SW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .q_slot    (head_slot),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

FILE: design/bavg_checker.sv
// Port-level checks for the 2x2 box-average downscaler, bound to its top level.
// Depends on bavg_pkg and box_average_downscale_2x.
`timescale 1ns / 1ps

module bavg_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_stall,
    input  logic            out_valid,
    input  logic            out_stall,
    input  bavg_pkg::res_t  out_data
);

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // A result is withdrawn only after it was taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped while stalled");

    // The last pixel of the frame also closes its row.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.frame_end || out_data.row_end))
        else $error("frame_end without row_end");

    // The input can only become stalled right after an item was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall))
        else $error("input stall rose without an accepted item");

endmodule

bind box_average_downscale_2x bavg_checker u_bavg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

FILE: verif/bavg_result_checker.sv
// Result checker for the 2x2 box-average downscaler: watches the pixel, result and
// register ports, predicts each averaged pixel and compares it with what comes out.
// Depends on bavg_pkg.
`timescale 1ns / 1ps

module bavg_result_checker
    import bavg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  pix_t                   in_data,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  res_t                   out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    output int                     fail_count,
    output int                     pending
);

    localparam int LINE_SLOTS = MAX_WIDTH_DEF / 2;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pair_t            pair_line [LINE_SLOTS];
    pix_t             held;
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    res_t             expected_averages [$];
    res_t             oldest;
    int               errors = 0;

    assign fail_count = errors;

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return 32'(v);
    endfunction

    function automatic logic [7:0] block_avg(logic [8:0] upper, logic [8:0] lower);
        logic [9:0] total;
        total = 10'(upper) + 10'(lower);
        return total[9:2];
    endfunction

    // Even rows park their pair sums in the line; odd rows finish the block.
    task automatic downscale_pixel(input pix_t p);
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        pair_t       pr;
        res_t        r;
        w = clamp_dim(width_reg, MAX_WIDTH_DEF);
        h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
        if (col_cnt < w && row_cnt < h)
        begin
            if (col_cnt % 2 == 0)
            begin
                held = p;
            end
            else
            begin
                slot     = (col_cnt / 2) % LINE_SLOTS;
                pr.red   = 9'(held.red_in) + 9'(p.red_in);
                pr.green = 9'(held.green_in) + 9'(p.green_in);
                pr.blue  = 9'(held.blue_in) + 9'(p.blue_in);
                if (row_cnt % 2 == 0)
                begin
                    pair_line[slot] = pr;
                end
                else
                begin
                    r.red_out   = block_avg(pair_line[slot].red, pr.red);
                    r.green_out = block_avg(pair_line[slot].green, pr.green);
                    r.blue_out  = block_avg(pair_line[slot].blue, pr.blue);
                    r.row_end   = (col_cnt == (w & ~32'd1) - 1);
                    r.frame_end = r.row_end && (row_cnt == (h & ~32'd1) - 1);
                    expected_averages.push_back(r);
                end
            end
        end
        col_cnt++;
        if (col_cnt >= w)
        begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h)
                row_cnt = 0;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = CFG_W'(WIDTH_RESET);
            height_reg = CFG_W'(HEIGHT_RESET);
            held       = '0;
            col_cnt    = 0;
            row_cnt    = 0;
            expected_averages.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_averages.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, got r=%0d g=%0d b=%0d re=%0b fe=%0b",
                             $time, out_data.red_out, out_data.green_out, out_data.blue_out,
                             out_data.row_end, out_data.frame_end);
                end
                else
                begin
                    oldest = expected_averages.pop_front();
                    check_field("red_out", oldest.red_out, out_data.red_out);
                    check_field("green_out", oldest.green_out, out_data.green_out);
                    check_field("blue_out", oldest.blue_out, out_data.blue_out);
                    check_field("row_end", 8'(oldest.row_end), 8'(out_data.row_end));
                    check_field("frame_end", 8'(oldest.frame_end), 8'(out_data.frame_end));
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data;
            end
            if (in_valid && !in_stall)
                downscale_pixel(in_data);
            pending <= expected_averages.size();
        end
    end

endmodule

FILE: verif/box_average_downscale_2x_tb.sv
// Testbench top for the 2x2 box-average downscaler: clock, reset, pixel stimulus,
// register writes, output back-pressure and the verdict.
// Depends on bavg_pkg, box_average_downscale_2x and bavg_result_checker.
`timescale 1ns / 1ps

module box_average_downscale_2x_tb;
    import bavg_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_ITEMS  = 880;
    localparam int TALL_ITEMS    = 64;
    localparam int HOLD_PHASE    = 2;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_e;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    pix_t                   in_data;
    logic                   out_valid;
    logic                   out_stall;
    res_t                   out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    int fail_count;
    int pending;
    bit hold_req    = 1'b0;
    int burst_left  = 0;
    int idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    box_average_downscale_2x u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bavg_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offers one item and returns after the edge that takes it. A burst that runs out
    // drops valid before offering again, so valid is never lowered and raised at once.
    task automatic send_pixel(input pix_t p);
        in_data  <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
            burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 40)
                                                     : $urandom_range(16, 1);
        end
    endtask

    task automatic stream_random_pixels(input int count);
        repeat (count) send_pixel(pix_t'(24'($urandom)));
    endtask

    // Registers change only once the block has drained and its pipeline has settled.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_W-1:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                               input int unsigned hi);
        if (v < CFG_W'(2))
            return 2;
        if (32'(v) > hi)
            return hi;
        return 32'(v);
    endfunction

    // Mostly small sizes, some larger; some below the range, which act as two.
    function automatic logic [CFG_W-1:0] pick_size(input int unsigned small_hi);
        int unsigned sel;
        sel = $urandom_range(9, 0);
        if (sel <= 5)
            return CFG_W'($urandom_range(small_hi, 2));
        if (sel == 6)
            return CFG_W'($urandom_range(2 * small_hi, small_hi + 1));
        if (sel == 7)
            return CFG_W'($urandom_range(1, 0));
        return CFG_W'(2);
    endfunction

    initial
    begin
        int               sent;
        int               phase;
        int               count;
        logic [CFG_W-1:0] size_w;
        logic [CFG_W-1:0] size_h;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= '0;
        burst_left = $urandom_range(16, 1);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Smallest frame at full and zero intensity.
        set_size(CFG_W'(2), CFG_W'(2));
        repeat (4) send_pixel({8'hFF, 8'hFF, 8'hFF});
        repeat (4) send_pixel('0);

        // Odd width and height: the last column and row are dropped, sums truncate.
        set_size(CFG_W'(3), CFG_W'(3));
        send_pixel({8'd1, 8'd2, 8'd3});
        send_pixel({8'd2, 8'd1, 8'd0});
        send_pixel({8'd9, 8'd9, 8'd9});
        send_pixel({8'd0, 8'd0, 8'd1});
        send_pixel({8'd0, 8'd1, 8'd2});
        send_pixel({8'd200, 8'd200, 8'd200});
        send_pixel({8'hFF, 8'h00, 8'hFF});
        send_pixel({8'h00, 8'hFF, 8'h00});
        send_pixel({8'h80, 8'h80, 8'h80});

        // Register values below the range clamp to the smallest size.
        set_size(CFG_W'(0), CFG_W'(1));
        send_pixel({8'h80, 8'h7F, 8'h01});
        send_pixel({8'h7F, 8'h80, 8'hFE});
        send_pixel({8'h55, 8'hAA, 8'h00});
        send_pixel({8'hAA, 8'h55, 8'hFF});

        // Width cut in mid-row: the column beyond it wraps on the next item, and the
        // odd row that follows reads pair sums written under the wider size.
        set_size(CFG_W'(12), CFG_W'(4));
        stream_random_pixels(29);
        write_reg(REG_IMAGE_WIDTH, CFG_W'(4));
        stream_random_pixels(5);

        // Height cut in mid-frame: the rows beyond it give no result and then wrap.
        set_size(CFG_W'(4), CFG_W'(8));
        stream_random_pixels(22);
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(4));
        stream_random_pixels(2);

        // Whole frames only, so every size change lands on a frame start.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase == HOLD_PHASE)
            begin
                set_size(CFG_W'(12), CFG_W'(8));
                hold_req = 1'b1;
                count    = 2 * 12 * 8;
            end
            else
            begin
                size_w = pick_size(12);
                size_h = pick_size(8);
                set_size(size_w, size_h);
                count = int'(clamp_size(size_w, MAX_WIDTH_DEF) *
                             clamp_size(size_h, MAX_HEIGHT_DEF));
                if (count <= 48)
                    count = count * int'($urandom_range(3, 1));
            end
            stream_random_pixels(count);
            sent += count;
            phase++;
        end

        // Height above the range is clamped; the top of such a tall frame is enough.
        set_size(CFG_W'(2), CFG_W'(2047));
        stream_random_pixels(TALL_ITEMS);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Output back-pressure in segments of random mode and length, plus one long hold.
    initial
    begin
        stall_mode_e mode;
        int          seg_left;
        int          hold_cnt;
        bit          hold_used;
        bit          toggle;
        out_stall <= 1'b0;
        mode      = STALL_NONE;
        seg_left  = 0;
        hold_used = 1'b0;
        toggle    = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
            end
            if (seg_left == 0)
            begin
                mode     = stall_mode_e'($urandom_range(3, 0));
                seg_left = $urandom_range(40, 1);
            end
            seg_left--;
            toggle = ~toggle;
            case (mode)
                STALL_NONE:      out_stall <= 1'b0;
                STALL_LIGHT:     out_stall <= ($urandom_range(3, 0) == 0);
                STALL_HEAVY:     out_stall <= ($urandom_range(3, 0) != 0);
                STALL_ALTERNATE: out_stall <= toggle;
                default:         out_stall <= 1'b0;
            endcase
        end
    end

    // Ends the run if no item moves on either channel for too long.
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILED: results differ");
        $finish;
    end

endmodule
